>>> hw/rtl/bfe_pkg.sv
// Shared types and constants for the Bloom filter bit-array engine.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`timescale 1ns / 1ps

package bfe_pkg;

  localparam int MAX_BITS    = 65536;
  localparam int MAX_HASHES  = 16;

  localparam int HASH_W      = 64;
  localparam int BITCNT_W    = 17;
  localparam int HASHCNT_W   = 5;
  localparam int POS_W       = $clog2(MAX_BITS);
  localparam int ROW_W       = 32;
  localparam int ROW_BIT_W   = $clog2(ROW_W);
  localparam int ROWS        = MAX_BITS / ROW_W;
  localparam int ROW_ADDR_W  = POS_W - ROW_BIT_W;
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  localparam logic [BITCNT_W-1:0]  BIT_COUNT_RST  = BITCNT_W'(MAX_BITS);
  localparam logic [HASHCNT_W-1:0] HASH_COUNT_RST = HASHCNT_W'(7);

  typedef enum logic [0:0] {
    CFG_BIT_COUNT  = 1'b0,
    CFG_HASH_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [ROW_ADDR_W-1:0] waddr;
    logic [ROW_W-1:0]      wdata;
    logic [ROW_ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

>>> hw/rtl/bfe_mod_unit.sv
// Iterative remainder unit: 64-bit dividend modulo a 17-bit modulus, four bits per cycle.
// Depends on bfe_pkg for widths.
`timescale 1ns / 1ps

module bfe_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bfe_pkg::HASH_W-1:0]     dividend,
  input  logic [bfe_pkg::BITCNT_W-1:0]   modulus,
  output logic                           busy,
  output logic [bfe_pkg::POS_W-1:0]      remainder
);

  logic                            busy_r, busy_nxt;
  logic [bfe_pkg::MOD_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bfe_pkg::HASH_W-1:0]      div_r, div_nxt;
  logic [bfe_pkg::BITCNT_W-1:0]    rem_r, rem_nxt;
  logic [bfe_pkg::BITCNT_W-1:0]    rem_step;

  // The remainder stays below the modulus, so each step needs one extra bit.
  always_comb begin
    logic [bfe_pkg::BITCNT_W:0] t;
    t        = '0;
    rem_step = rem_r;
    for (int s = 0; s < bfe_pkg::MOD_DIGIT_W; s++) begin
      t = {rem_step, div_r[bfe_pkg::HASH_W-1-s]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_step = t[bfe_pkg::BITCNT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      div_nxt = div_r << bfe_pkg::MOD_DIGIT_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bfe_pkg::MOD_CNT_W'(bfe_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r[bfe_pkg::POS_W-1:0];

endmodule

>>> hw/rtl/bfe_bit_store.sv
// Filter bit array held as 32-bit rows, one write and one registered read per cycle.
// Depends on bfe_pkg for the row geometry and the request struct.
`timescale 1ns / 1ps

module bfe_bit_store (
  input  logic                          clk,
  input  bfe_pkg::store_req_t           req,
  output logic [bfe_pkg::ROW_W-1:0]     rdata
);

  logic [bfe_pkg::ROW_W-1:0] mem [bfe_pkg::ROWS];
  logic [bfe_pkg::ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bloom_filter_engine_core.sv
// Bloom filter engine: add, query and clear over a 65536-bit store kept in 32-bit rows.
// Add or query runs these steps for each derived position: multiply, increment, 16 remainder
// steps, row read, check/update, between accepting the item and handing off the result;
// a query stops at the first clear bit. Clear sweeps 2048 rows, one a cycle.
// One item is in work at a time; the result sits in an output register while the next
// item may be accepted. After reset a sweep clears all 2048 rows before in_tready rises.
`timescale 1ns / 1ps

module bloom_filter_engine_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] hash_a, [127:64] hash_b
  input  logic [1:0]   in_tuser,   // [1:0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // [0] maybe_present, [7:1] zero
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [16:0]  cfg_wdata
);

  bfe_pkg::state_t                    state_r, state_nxt;
  logic [bfe_pkg::BITCNT_W-1:0]       bit_count_r;
  logic [bfe_pkg::HASHCNT_W-1:0]      hash_count_r;
  logic [bfe_pkg::BITCNT_W-1:0]       n_r, n_nxt;
  logic [bfe_pkg::HASHCNT_W-1:0]      i_r, i_nxt;
  logic [bfe_pkg::HASH_W-1:0]         ab_r, ab_nxt;
  logic [bfe_pkg::HASH_W-1:0]         prod_r, prod_nxt;
  bfe_pkg::func_t                     func_r, func_nxt;
  logic [bfe_pkg::ROW_ADDR_W-1:0]     row_r, row_nxt;
  logic                               ans_r, ans_nxt;
  logic                               out_tvalid_r, out_tvalid_nxt;
  logic                               out_bit_r, out_bit_nxt;

  logic [bfe_pkg::BITCNT_W-1:0]       n_eff;
  logic [bfe_pkg::HASHCNT_W-1:0]      k_eff;
  logic [bfe_pkg::HASH_W+bfe_pkg::HASHCNT_W-1:0] prod_full;
  logic                               mod_start;
  logic [bfe_pkg::HASH_W-1:0]         mod_dividend;
  logic                               mod_busy;
  logic [bfe_pkg::POS_W-1:0]          pos;
  bfe_pkg::store_req_t                store_req;
  logic [bfe_pkg::ROW_W-1:0]          row_data;
  logic                               cur_bit;
  bfe_pkg::func_t                     in_func;

  assign in_func = bfe_pkg::func_t'(in_tuser);

  // A zero bit count acts as one; counts past the store size saturate.
  always_comb begin
    if (bit_count_r == '0) begin
      n_eff = bfe_pkg::BITCNT_W'(1);
    end else if (bit_count_r > bfe_pkg::BITCNT_W'(bfe_pkg::MAX_BITS)) begin
      n_eff = bfe_pkg::BITCNT_W'(bfe_pkg::MAX_BITS);
    end else begin
      n_eff = bit_count_r;
    end
    if (hash_count_r > bfe_pkg::HASHCNT_W'(bfe_pkg::MAX_HASHES)) begin
      k_eff = bfe_pkg::HASHCNT_W'(bfe_pkg::MAX_HASHES);
    end else begin
      k_eff = hash_count_r;
    end
  end

  assign prod_full = (ab_r ^ {{(bfe_pkg::HASH_W-bfe_pkg::HASHCNT_W){1'b0}}, i_r}) * i_r;
  assign cur_bit   = row_data[pos[bfe_pkg::ROW_BIT_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= bfe_pkg::BIT_COUNT_RST;
      hash_count_r <= bfe_pkg::HASH_COUNT_RST;
    end else if (cfg_we) begin
      case (bfe_pkg::cfg_idx_t'(cfg_index))
        bfe_pkg::CFG_BIT_COUNT:  bit_count_r  <= cfg_wdata;
        bfe_pkg::CFG_HASH_COUNT: hash_count_r <= cfg_wdata[bfe_pkg::HASHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    ab_nxt         = ab_r;
    prod_nxt       = prod_r;
    func_nxt       = func_r;
    row_nxt        = row_r;
    ans_nxt        = ans_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_bit_nxt    = out_bit_r;
    mod_start      = 1'b0;
    mod_dividend   = prod_r + 64'd1;
    store_req.we    = 1'b0;
    store_req.waddr = pos[bfe_pkg::POS_W-1:bfe_pkg::ROW_BIT_W];
    store_req.wdata = row_data | (bfe_pkg::ROW_W'(1) << pos[bfe_pkg::ROW_BIT_W-1:0]);
    store_req.raddr = pos[bfe_pkg::POS_W-1:bfe_pkg::ROW_BIT_W];
    in_tready      = 1'b0;

    case (state_r)
      bfe_pkg::ST_WIPE, bfe_pkg::ST_CLEAR: begin
        store_req.we    = 1'b1;
        store_req.waddr = row_r;
        store_req.wdata = '0;
        row_nxt         = row_r + 1'b1;
        if (row_r == bfe_pkg::ROW_ADDR_W'(bfe_pkg::ROWS - 1)) begin
          state_nxt = (state_r == bfe_pkg::ST_WIPE) ? bfe_pkg::ST_IDLE : bfe_pkg::ST_DONE;
        end
      end
      bfe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ab_nxt   = in_tdata[63:0] ^ in_tdata[127:64];
          func_nxt = in_func;
          n_nxt    = n_eff;
          i_nxt    = k_eff;
          ans_nxt  = 1'b0;
          row_nxt  = '0;
          case (in_func)
            bfe_pkg::FUNC_ADD, bfe_pkg::FUNC_QUERY: begin
              if (k_eff == '0) begin
                // With no positions a query finds nothing clear.
                ans_nxt   = (in_func == bfe_pkg::FUNC_QUERY);
                state_nxt = bfe_pkg::ST_DONE;
              end else begin
                state_nxt = bfe_pkg::ST_MUL;
              end
            end
            bfe_pkg::FUNC_CLEAR: state_nxt = bfe_pkg::ST_CLEAR;
            default:             state_nxt = bfe_pkg::ST_DONE;
          endcase
        end
      end
      bfe_pkg::ST_MUL: begin
        prod_nxt  = prod_full[bfe_pkg::HASH_W-1:0];
        state_nxt = bfe_pkg::ST_ADD;
      end
      bfe_pkg::ST_ADD: begin
        mod_start = 1'b1;
        state_nxt = bfe_pkg::ST_DIV;
      end
      bfe_pkg::ST_DIV: begin
        if (!mod_busy) begin
          state_nxt = bfe_pkg::ST_RD;
        end
      end
      bfe_pkg::ST_RD: begin
        state_nxt = bfe_pkg::ST_CHK;
      end
      bfe_pkg::ST_CHK: begin
        if (func_r == bfe_pkg::FUNC_ADD) begin
          store_req.we = 1'b1;
          if (i_r == bfe_pkg::HASHCNT_W'(1)) begin
            ans_nxt   = 1'b0;
            state_nxt = bfe_pkg::ST_DONE;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = bfe_pkg::ST_MUL;
          end
        end else if (!cur_bit) begin
          ans_nxt   = 1'b0;
          state_nxt = bfe_pkg::ST_DONE;
        end else if (i_r == bfe_pkg::HASHCNT_W'(1)) begin
          ans_nxt   = 1'b1;
          state_nxt = bfe_pkg::ST_DONE;
        end else begin
          i_nxt     = i_r - 1'b1;
          state_nxt = bfe_pkg::ST_MUL;
        end
      end
      bfe_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_bit_nxt    = ans_r;
          state_nxt      = bfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfe_pkg::ST_WIPE;
      row_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    ab_r      <= ab_nxt;
    prod_r    <= prod_nxt;
    func_r    <= func_nxt;
    ans_r     <= ans_nxt;
    out_bit_r <= out_bit_nxt;
  end

  bfe_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .modulus   (n_r),
    .busy      (mod_busy),
    .remainder (pos)
  );

  bfe_bit_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (row_data)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_bit_r};

endmodule

>>> sim/bloom_filter_engine_core_test.sv
// Self-checking testbench for bloom_filter_engine_core: directed and random add, query,
// clear and unused items under a range of bit and hash counts, checked against a shadow filter.
// Depends on hw/rtl/bfe_pkg.sv and hw/rtl/bloom_filter_engine_core.sv.
`timescale 1ns / 1ps

module bloom_filter_engine_core_test;
  import bfe_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 100;
  localparam int POOL_DEPTH    = 48;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [63:0] b;
    logic [63:0] a;
  } key_t;

  // Shadow copy of the filter store and registers; predicts one answer per accepted item.
  class bloom_shadow;
    bit                   filter_bits[MAX_BITS];
    logic [BITCNT_W-1:0]  bit_count;
    logic [HASHCNT_W-1:0] hash_count;
    logic                 pending_answers[$];
    int                   errors;

    function new();
      foreach (filter_bits[j]) filter_bits[j] = 1'b0;
      bit_count  = BIT_COUNT_RST;
      hash_count = HASH_COUNT_RST;
      errors     = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [16:0] value);
      if (idx == CFG_BIT_COUNT) bit_count = value[BITCNT_W-1:0];
      else hash_count = value[HASHCNT_W-1:0];
    endfunction

    function bit [63:0] bits_in_use();
      if (bit_count == 0) return 64'd1;
      if (bit_count > MAX_BITS) return 64'(MAX_BITS);
      return 64'(bit_count);
    endfunction

    function int hashes_in_use();
      if (hash_count > MAX_HASHES) return MAX_HASHES;
      return int'(hash_count);
    endfunction

    // Position i of a key, with the product wrapping at 64 bits before the remainder.
    function bit [15:0] position(key_t key, bit [63:0] i, bit [63:0] n);
      bit [63:0] mixed;
      mixed = (key.b ^ key.a ^ i) * i + 64'd1;
      return 16'(mixed % n);
    endfunction

    function void note_item(func_t f, key_t key);
      bit [63:0] n;
      logic      answer;
      n      = bits_in_use();
      answer = 1'b0;
      case (f)
        FUNC_ADD: begin
          for (int i = hashes_in_use(); i > 0; i--)
            filter_bits[position(key, 64'(i), n)] = 1'b1;
        end
        FUNC_QUERY: begin
          answer = 1'b1;
          for (int i = hashes_in_use(); i > 0; i--) begin
            if (!filter_bits[position(key, 64'(i), n)]) begin
              answer = 1'b0;
              break;
            end
          end
        end
        FUNC_CLEAR: begin
          foreach (filter_bits[j]) filter_bits[j] = 1'b0;
        end
        default: ;
      endcase
      pending_answers.push_back(answer);
    endfunction

    function void check_answer(logic [7:0] tdata);
      logic [7:0] want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, tdata);
        errors++;
        return;
      end
      want = {7'b0, pending_answers.pop_front()};
      if (tdata !== want) begin
        $display("%0t: result mismatch, expected %h, got %h", $time, want, tdata);
        errors++;
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // [63:0] hash_a, [127:64] hash_b
  logic [1:0]   in_tuser = '0;   // [1:0] func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;       // [0] maybe_present, [7:1] zero
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [16:0]  cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int cycles = 0;

  bloom_shadow shadow = new();

  bloom_filter_engine_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bloom_filter_engine_core_test NOT OK");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_answer(out_tdata);
  end

  function automatic key_t random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_item(func_t f, key_t key);
    in_tvalid <= 1'b1;
    in_tdata  <= {key.b, key.a};
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    shadow.note_item(f, key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Registers change only once every outstanding item has answered.
  task automatic write_regs(logic [16:0] bits, logic [16:0] hashes);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BIT_COUNT;
    cfg_wdata <= bits;
    @(posedge clk);
    shadow.write_register(CFG_BIT_COUNT, bits);
    cfg_index <= CFG_HASH_COUNT;
    cfg_wdata <= hashes;
    @(posedge clk);
    shadow.write_register(CFG_HASH_COUNT, hashes);
    cfg_we <= 1'b0;
  endtask

  initial begin
    key_t        ones_key;
    key_t        mixed_key;
    key_t        k1;
    key_t        k2;
    key_t        key;
    key_t        key_pool[$];
    logic [16:0] phase_bits[PHASES];
    logic [16:0] phase_hashes[PHASES];
    int          r;

    phase_bits   = '{65536, 1, 8, 0, 131071, 100, 0, 1000, 65535, 37, 0, 65536, 16, 0};
    phase_hashes = '{7, 3, 16, 4, 31, 0, 0, 2, 16, 5, 0, 1, 12, 0};
    phase_bits[6]    = 17'($urandom_range(131071, 1));
    phase_hashes[6]  = 17'($urandom_range(16, 1));
    phase_bits[10]   = 17'($urandom_range(131071, 1));
    phase_hashes[10] = 17'($urandom_range(31));
    phase_bits[13]   = 17'($urandom);
    phase_hashes[13] = 17'($urandom_range(31));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: store extremes, every operation, and the register corner cases.
    ones_key  = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    mixed_key = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_ADD, '0);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_ADD, ones_key);
    send_item(FUNC_ADD, mixed_key);
    send_item(FUNC_QUERY, mixed_key);
    send_item(FUNC_QUERY, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    send_item(FUNC_UNUSED, ones_key);
    send_item(FUNC_CLEAR, random_key());
    send_item(FUNC_QUERY, mixed_key);

    // A bit count of zero collapses every position onto bit zero; no hashes means no work.
    k1 = random_key();
    write_regs(17'd0, 17'd0);
    send_item(FUNC_ADD, k1);
    send_item(FUNC_QUERY, k1);
    write_regs(17'd0, 17'd5);
    send_item(FUNC_ADD, k1);
    send_item(FUNC_QUERY, k1);

    // Out-of-range counts saturate; clear must wipe bits beyond the count in use.
    k2 = random_key();
    write_regs(17'h1FFFF, 17'h1F);
    send_item(FUNC_ADD, k2);
    send_item(FUNC_QUERY, k2);
    write_regs(17'd100, 17'd3);
    send_item(FUNC_CLEAR, k1);
    write_regs(17'd65536, 17'h1F);
    send_item(FUNC_QUERY, k2);
    send_item(FUNC_ADD, k2);
    // The store keeps its contents when the bit count changes; nothing is rehashed.
    write_regs(17'h1FFFF, 17'd16);
    send_item(FUNC_QUERY, k2);
    write_regs(17'd65535, 17'd16);
    send_item(FUNC_QUERY, k2);

    for (int p = 0; p < PHASES; p++) begin
      write_regs(phase_bits[p], phase_hashes[p]);
      if (p < 5) begin
        send_idle_pct = 14;
        recv_idle_pct = 79;
      end else if (p < 10) begin
        send_idle_pct = 79;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 11) hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if ($urandom_range(99) < 3) key = ($urandom_range(1) != 0) ? ones_key : '0;
        else key = random_key();
        if (r < 2) begin
          send_item(FUNC_CLEAR, key);
        end else if (r < 5) begin
          send_item(FUNC_UNUSED, key);
        end else if (r < 50) begin
          key_pool.push_back(key);
          if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
          send_item(FUNC_ADD, key);
        end else begin
          // Mostly keys already added, some with one bit flipped, the rest fresh.
          if (key_pool.size() != 0 && $urandom_range(99) < 70) begin
            key = key_pool[$urandom_range(key_pool.size() - 1)];
            if ($urandom_range(99) < 20) key[$urandom_range(127)] ^= 1'b1;
          end
          send_item(FUNC_QUERY, key);
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("bloom_filter_engine_core_test OK");
    end else begin
      $display("bloom_filter_engine_core_test NOT OK");
    end
    $finish;
  end

endmodule
